### sv/job_queue_delete_by_key_assert.svh
// Assertion macros shared by the checker.
`ifndef JOB_QUEUE_DELETE_BY_KEY_ASSERT_SVH
`define JOB_QUEUE_DELETE_BY_KEY_ASSERT_SVH

// Checked only while out of reset.
`define JQD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define JQD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/jqd_pkg.sv
package jqd_pkg;

    localparam int FUNC_W   = 2;
    localparam int JOB_W    = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_DUMP   = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_ENTRY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_REPORT,
        S_DUMP
    } t_state;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic keep;
        logic add;
    } t_cell_ctl;

endpackage

### sv/jqd_if.sv
interface jqd_in_if;
    import jqd_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [JOB_W-1:0]    job_number;

    modport source (output valid, func, job_number, input ready);
    modport sink   (input valid, func, job_number, output ready);
endinterface

interface jqd_out_if;
    import jqd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    job_out;
    logic                last;

    modport source (output valid, status, job_out, last, input ready);
    modport sink   (input valid, status, job_out, last, output ready);
endinterface

### sv/jqd_cell.sv
module jqd_cell #(
    parameter int W   = 16,
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  jqd_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]     i_tail,
    input  logic [W-1:0]      i_next,
    input  logic [W-1:0]      i_head,
    input  logic [W-1:0]      i_job,
    output logic [W-1:0]      o_data
);
    import jqd_pkg::*;

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;
    logic         w_at_tail;

    assign w_at_tail = (i_tail == IW'(IDX));

    // On a shift take the neighbour's entry; the tail cell takes the recycled head instead when it is kept
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = (i_ctl.keep && w_at_tail) ? i_head : i_next;
        end else if (i_ctl.add && w_at_tail) begin
            n_data = i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### sv/jqd_seq.sv
module jqd_seq #(
    parameter int DEPTH = 16,
    parameter int JW    = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    jqd_in_if.sink             i_in,
    jqd_out_if.source          o_out,
    input  logic [JW-1:0]      i_head,
    output jqd_pkg::t_cell_ctl o_ctl,
    output logic [IW-1:0]      o_tail,
    output logic [JW-1:0]      o_job
);
    import jqd_pkg::*;

    t_state               r_state,  n_state;
    logic [CW-1:0]        r_count,  n_count;
    logic [CW-1:0]        r_len,    n_len;
    logic [CW-1:0]        r_left,   n_left;
    logic                 r_found,  n_found;
    logic [JW-1:0]        r_key,    n_key;
    logic                 r_ovalid, n_ovalid;
    t_status              r_status, n_status;
    logic [JOB_W-1:0]     r_ojob,   n_ojob;
    logic                 r_olast,  n_olast;

    logic                 w_free;
    logic                 w_full;
    logic                 w_match;
    logic [JW-1:0]        w_job;
    logic [CW-1:0]        w_len_m1;
    logic [CW-1:0]        w_cnt_m1;

    assign w_free   = !r_ovalid || o_out.ready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_match  = !r_found && (i_head == r_key);
    assign w_job    = i_in.job_number[JW-1:0];
    assign w_len_m1 = r_len - CW'(1);
    assign w_cnt_m1 = r_count - CW'(1);
    assign o_job    = w_job;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_len     = r_len;
        n_left    = r_left;
        n_found   = r_found;
        n_key     = r_key;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_status  = r_status;
        n_ojob    = r_ojob;
        n_olast   = r_olast;
        o_ctl     = '0;
        o_tail    = r_count[IW-1:0];
        i_in.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = w_free;
                if (i_in.valid && w_free) begin
                    unique case (t_func'(i_in.func))
                        FN_ADD: begin
                            n_ovalid = 1'b1;
                            n_olast  = 1'b1;
                            n_ojob   = JOB_W'(w_job);
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status  = ST_ADDED;
                                o_ctl.add = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        FN_REMOVE: begin
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_ojob   = JOB_W'(w_job);
                                n_status = ST_EMPTY;
                            end else begin
                                n_key   = w_job;
                                n_len   = r_count;
                                n_left  = r_count;
                                n_found = 1'b0;
                                n_state = S_REMOVE;
                            end
                        end
                        FN_DUMP: begin
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_ojob   = '0;
                                n_status = ST_EMPTY;
                            end else begin
                                n_left  = r_count;
                                n_state = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REMOVE: begin
                // Pop the head; recycle it at the tail unless it is the first match
                o_ctl.shift = 1'b1;
                o_ctl.keep  = !w_match;
                o_tail      = w_len_m1[IW-1:0];
                if (w_match) begin
                    n_len   = w_len_m1;
                    n_found = 1'b1;
                end
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    n_ojob   = JOB_W'(r_key);
                    n_status = r_found ? ST_REMOVED : ST_NOTFOUND;
                    n_count  = r_len;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                o_tail = w_cnt_m1[IW-1:0];
                if (w_free) begin
                    o_ctl.shift = 1'b1;
                    o_ctl.keep  = 1'b1;
                    n_ovalid    = 1'b1;
                    n_ojob      = JOB_W'(i_head);
                    n_status    = ST_ENTRY;
                    n_olast     = (r_left == CW'(1));
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_left   <= n_left;
        r_found  <= n_found;
        r_key    <= n_key;
        r_status <= n_status;
        r_ojob   <= n_ojob;
        r_olast  <= n_olast;
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.status  = r_status;
    assign o_out.job_out = r_ojob;
    assign o_out.last    = r_olast;

endmodule

### sv/job_queue_delete_by_key.sv
// Bounded job queue of DEPTH entries held in a chain of cells, head in cell 0. An add writes the
// tail cell and is done in the cycle it is taken, as is any operation on an empty queue, a full
// add or an unused code; its result is valid from the next cycle. Remove and dump rotate the
// whole queue once through the chain, one entry per cycle, a dump only while the output
// register can take a result: a remove takes the item, rotates each entry, then reports once
// the output register is free; a dump takes the item, then sends one entry out per step.
// Remove drops the first matching entry during the rotation, so order is kept. Results leave
// through a one-item output register; a new item is taken once the previous one has finished
// and the output register can take a result.
module job_queue_delete_by_key #(
    parameter int DEPTH    = 16,
    parameter int JOB_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jqd_in_if.sink    i_job,
    jqd_out_if.source o_res
);
    import jqd_pkg::*;

    localparam int JW = (JOB_BITS < JOB_W) ? JOB_BITS : JOB_W;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cell_ctl     w_ctl;
    logic [IW-1:0] w_tail;
    logic [JW-1:0] w_job;
    logic [JW-1:0] w_data [DEPTH];

    jqd_seq #(
        .DEPTH (DEPTH),
        .JW    (JW),
        .IW    (IW),
        .CW    (CW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_job),
        .o_out   (o_res),
        .i_head  (w_data[0]),
        .o_ctl   (w_ctl),
        .o_tail  (w_tail),
        .o_job   (w_job)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [JW-1:0] w_next;

        if (g == DEPTH - 1) begin : g_end
            assign w_next = w_data[0];
        end else begin : g_mid
            assign w_next = w_data[g + 1];
        end

        jqd_cell #(
            .W   (JW),
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_tail (w_tail),
            .i_next (w_next),
            .i_head (w_data[0]),
            .i_job  (w_job),
            .o_data (w_data[g])
        );
    end

endmodule

### sv/jqd_checker.sv
`include "job_queue_delete_by_key_assert.svh"

module jqd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [jqd_pkg::STATUS_W-1:0] i_status,
    input logic [jqd_pkg::JOB_W-1:0]    i_job_out,
    input logic                         i_last
);
    import jqd_pkg::*;

    // Hold a stalled result
    `JQD_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status) && $stable(i_job_out) && $stable(i_last)), "stalled result changed")

    // Reset empties the output register
    `JQD_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Only a dump gives more than one result per item
    `JQD_ASSERT(a_multi_is_dump, i_clk, i_rst_n, (i_out_valid && !i_last) |-> (i_status == ST_ENTRY), "non-final result is not a dump entry")

    // No new item while a dump is still under way
    `JQD_ASSERT(a_dump_blocks, i_clk, i_rst_n, (i_out_valid && !i_last) |-> !(i_in_valid && i_in_ready), "item taken during dump")

endmodule

bind job_queue_delete_by_key jqd_checker u_jqd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_job.valid),
    .i_in_ready  (i_job.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_job_out   (o_res.job_out),
    .i_last      (o_res.last)
);

### dv/testbench.sv
module testbench;
    import jqd_pkg::*;

    localparam int                DEPTH          = 16;
    localparam int                RANDOM_OPS     = 320;
    localparam int                MAX_WAIT       = 10;
    localparam int                DRAIN_CYCLES   = 40;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam logic [FUNC_W-1:0] FN_UNUSED      = 2'd3;
    localparam int                PREDICTED      = -1;

    typedef struct packed {
        t_status          status;
        logic [JOB_W-1:0] job;
        logic             last;
    } t_job_result;

    // typed = PREDICTED: results come from the predictor, else the count of typed results
    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [JOB_W-1:0]  job;
        int                reps;
        int                typed;
        t_status           status;
        logic [JOB_W-1:0]  exp_job;
    } t_directed_op;

    logic clk = 1'b0;
    logic rst_n;

    jqd_in_if  job_if ();
    jqd_out_if res_if ();

    job_queue_delete_by_key #(
        .DEPTH    (DEPTH),
        .JOB_BITS (JOB_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    always #5 clk = ~clk;

    logic [JOB_W-1:0] queued_jobs [$];
    t_job_result      op_results [$];
    t_job_result      awaited_results [$];
    t_job_result      seen_exp;

    int  errors        = 0;
    int  checked       = 0;
    int  full_rejects  = 0;
    int  peak_fill     = 0;
    int  op_count [4]  = '{0, 0, 0, 0};
    int  idle_cycles   = 0;
    int  stall_left    = 0;
    int  stall_draw;
    bit  quiet_in      = 1'b0;
    bit  quiet_out     = 1'b0;

    t_directed_op directed_ops [15] = '{
        '{FN_DUMP,   16'h1234, 1,  1,         ST_EMPTY,    16'h0000}, // dump of an empty queue
        '{FN_REMOVE, 16'h1234, 1,  1,         ST_EMPTY,    16'h1234},
        '{FN_UNUSED, 16'hBEEF, 1,  0,         ST_ENTRY,    16'h0000}, // ignored, no result
        '{FN_ADD,    16'h0000, 1,  1,         ST_ADDED,    16'h0000},
        '{FN_ADD,    16'hFFFF, 1,  1,         ST_ADDED,    16'hFFFF},
        '{FN_ADD,    16'hFFFF, 1,  PREDICTED, ST_ENTRY,    16'h0000}, // duplicate
        '{FN_DUMP,   16'h0000, 1,  PREDICTED, ST_ENTRY,    16'h0000},
        '{FN_REMOVE, 16'h0001, 1,  1,         ST_NOTFOUND, 16'h0001},
        '{FN_REMOVE, 16'hFFFF, 1,  1,         ST_REMOVED,  16'hFFFF}, // nearest the head only
        '{FN_ADD,    16'h0100, 14, PREDICTED, ST_ENTRY,    16'h0000}, // fill to depth
        '{FN_ADD,    16'h7777, 1,  1,         ST_FULL,     16'h7777},
        '{FN_DUMP,   16'h0000, 1,  PREDICTED, ST_ENTRY,    16'h0000},
        '{FN_REMOVE, 16'h010D, 1,  PREDICTED, ST_ENTRY,    16'h0000}, // tail entry
        '{FN_REMOVE, 16'h0000, 1,  1,         ST_REMOVED,  16'h0000}, // head entry
        '{FN_DUMP,   16'h0000, 1,  PREDICTED, ST_ENTRY,    16'h0000}
    };

    function automatic void predict_job_op(input logic [FUNC_W-1:0] fn,
                                           input logic [JOB_W-1:0] job);
        int hit;
        hit = -1;
        op_results.delete();
        case (fn)
            FN_ADD: begin
                if (queued_jobs.size() >= DEPTH) begin
                    op_results.push_back('{ST_FULL, job, 1'b1});
                    full_rejects++;
                end else begin
                    queued_jobs.push_back(job);
                    op_results.push_back('{ST_ADDED, job, 1'b1});
                    if (queued_jobs.size() > peak_fill)
                        peak_fill = queued_jobs.size();
                end
            end
            FN_REMOVE: begin
                if (queued_jobs.size() == 0) begin
                    op_results.push_back('{ST_EMPTY, job, 1'b1});
                end else begin
                    foreach (queued_jobs[i])
                        if (hit < 0 && queued_jobs[i] == job)
                            hit = i;
                    if (hit < 0) begin
                        op_results.push_back('{ST_NOTFOUND, job, 1'b1});
                    end else begin
                        queued_jobs.delete(hit);
                        op_results.push_back('{ST_REMOVED, job, 1'b1});
                    end
                end
            end
            FN_DUMP: begin
                if (queued_jobs.size() == 0)
                    op_results.push_back('{ST_EMPTY, {JOB_W{1'b0}}, 1'b1});
                else
                    foreach (queued_jobs[i])
                        op_results.push_back('{ST_ENTRY, queued_jobs[i],
                                               i == queued_jobs.size() - 1});
            end
            default: ;
        endcase
    endfunction

    // Small pool half the time so duplicates and hits are common
    function automatic logic [JOB_W-1:0] pick_job();
        if ($urandom_range(0, 1) == 0)
            return JOB_W'($urandom_range(0, 5));
        return JOB_W'($urandom_range(0, 65535));
    endfunction

    task automatic issue_job_op(input logic [FUNC_W-1:0] fn, input logic [JOB_W-1:0] job,
                                input int typed, input t_status status,
                                input logic [JOB_W-1:0] exp_job);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_if.valid      <= 1'b1;
        job_if.func       <= fn;
        job_if.job_number <= job;
        do @(posedge clk); while (!job_if.ready);
        // valid stays high; the next call lowers it if it idles
        op_count[fn]++;
        predict_job_op(fn, job);
        if (typed == PREDICTED) begin
            foreach (op_results[i])
                awaited_results.push_back(op_results[i]);
        end else if (typed > 0) begin
            awaited_results.push_back('{status, exp_job, 1'b1});
        end
    endtask

    // Result side: draw a stall after every item taken
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= (stall_left == 1);
        end else if (res_if.valid && res_if.ready) begin
            stall_draw   = quiet_out ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left   <= stall_draw;
            res_if.ready <= (stall_draw == 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d job %h last %b", $time,
                         res_if.status, res_if.job_out, res_if.last);
            end else begin
                seen_exp = awaited_results.pop_front();
                checked++;
                if (res_if.status !== seen_exp.status || res_if.job_out !== seen_exp.job ||
                    res_if.last !== seen_exp.last) begin
                    errors++;
                    $display({"%0t: mismatch: expected status %0d job %h last %b, ",
                              "got status %0d job %h last %b"},
                             $time, seen_exp.status, seen_exp.job, seen_exp.last,
                             res_if.status, res_if.job_out, res_if.last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     idle_cycles, awaited_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int               counted;
        int               issued;
        int               pick;
        int               add_share;
        int               remove_share;
        bit               grow;
        logic [FUNC_W-1:0] fn;
        logic [JOB_W-1:0]  job;

        counted = 0;
        issued  = 0;
        grow    = 1'b0;

        rst_n             <= 1'b0;
        job_if.valid      <= 1'b0;
        job_if.func       <= FN_ADD;
        job_if.job_number <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[r])
            for (int k = 0; k < directed_ops[r].reps; k++)
                issue_job_op(directed_ops[r].fn, directed_ops[r].job + JOB_W'(k),
                             directed_ops[r].typed, directed_ops[r].status,
                             directed_ops[r].exp_job);

        // Alternate filling and draining phases so full and empty are both reached
        while (counted < RANDOM_OPS) begin
            if (issued % 40 == 0) begin
                grow      = ~grow;
                quiet_in  = ($urandom_range(0, 3) == 0);
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            add_share    = grow ? 60 : 25;
            remove_share = grow ? 20 : 50;
            pick         = $urandom_range(0, 99);
            if (pick < 4) begin
                fn  = FN_UNUSED;
                job = JOB_W'($urandom_range(0, 65535));
            end else if (pick < 4 + add_share) begin
                fn  = FN_ADD;
                job = pick_job();
            end else if (pick < 4 + add_share + remove_share) begin
                fn = FN_REMOVE;
                if (queued_jobs.size() != 0 && $urandom_range(0, 3) != 0)
                    job = queued_jobs[$urandom_range(0, queued_jobs.size() - 1)];
                else
                    job = pick_job();
            end else begin
                fn  = FN_DUMP;
                job = JOB_W'($urandom_range(0, 65535));
            end
            issue_job_op(fn, job, PREDICTED, ST_ENTRY, '0);
            issued++;
            if (fn != FN_UNUSED)
                counted++;
        end
        job_if.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d add, %0d remove, %0d dump and %0d unused requests; %0d results checked",
                 op_count[FN_ADD], op_count[FN_REMOVE], op_count[FN_DUMP],
                 op_count[FN_UNUSED], checked);
        $display("Queue peaked at %0d of %0d entries; %0d adds refused as full",
                 peak_fill, DEPTH, full_rejects);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
